FILE: hdl/mpd_pkg.sv
// shared types and constants for the mouse packet decoder
// no dependencies; used by every module under hdl
package mpd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned NUM_BTN = 3;
	localparam int unsigned NUM_EV = 2 + NUM_BTN;
	localparam int unsigned EV_IDX_W = $clog2(NUM_EV);
	localparam int unsigned OUT_DATA_W = 16;

	// header bit positions
	localparam int unsigned HDR_SYNC_BIT = 3;
	localparam int unsigned HDR_XSIGN_BIT = 4;
	localparam int unsigned HDR_YSIGN_BIT = 5;

	// event mask bit positions
	localparam logic [EV_IDX_W-1:0] EV_X = EV_IDX_W'(0);
	localparam logic [EV_IDX_W-1:0] EV_Y = EV_IDX_W'(1);
	localparam logic [EV_IDX_W-1:0] EV_BTN0 = EV_IDX_W'(2);

	typedef enum logic [1:0] {
		KIND_X_MOTION = 2'd0,
		KIND_Y_MOTION = 2'd1,
		KIND_BTN_DOWN = 2'd2,
		KIND_BTN_UP   = 2'd3
	} mpd_kind_t;

	// one decoded packet waiting for the event emitter
	typedef struct packed {
		logic [VALUE_W-1:0] dx;
		logic [VALUE_W-1:0] dy;
		logic [NUM_BTN-1:0] btn_now;
		logic [NUM_EV-1:0]  ev_mask;
	} mpd_rec_t;

endpackage

FILE: hdl/mpd_front.sv
// byte gatherer and packet classifier for the mouse packet decoder
// uses mpd_pkg; feeds decoded packets into mpd_queue
module mpd_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [mpd_pkg::BYTE_W-1:0]        rx_byte,
	input  logic                              rx_valid,
	output logic                              rx_ready,
	output mpd_pkg::mpd_rec_t                 rec,
	output logic                              rec_valid,
	input  logic                              rec_ready
);
	import mpd_pkg::*;

	logic [BYTE_W-1:0]  store0_q;
	logic [BYTE_W-1:0]  store1_q;
	logic [1:0]         cnt_q;
	logic [NUM_BTN-1:0] btn_q;

	logic               accept;
	logic               full_pkt;
	logic               in_sync;
	logic [VALUE_W-1:0] dy_raw;
	logic [NUM_BTN-1:0] btn_now;

	assign rx_ready = rec_ready;
	assign accept = rx_valid && rx_ready;
	assign full_pkt = (cnt_q == 2'd2);
	assign in_sync = store0_q[HDR_SYNC_BIT];
	assign btn_now = store0_q[NUM_BTN-1:0];
	assign dy_raw = {{2{store0_q[HDR_YSIGN_BIT]}}, rx_byte};

	always_comb begin
		rec.dx = {{2{store0_q[HDR_XSIGN_BIT]}}, store1_q};
		rec.dy = VALUE_W'(0) - dy_raw;
		rec.btn_now = btn_now;
		rec.ev_mask = {btn_now ^ btn_q, rec.dy != '0, rec.dx != '0};
		rec_valid = accept && full_pkt && in_sync && (rec.ev_mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			btn_q <= '0;
		end else if (accept) begin
			if (!full_pkt) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (in_sync) begin
				cnt_q <= 2'd0;
				btn_q <= btn_now;
			end
		end
	end

	// packet bytes, slide by one byte when the header is out of sync
	always_ff @(posedge clk) begin
		if (accept) begin
			if (cnt_q == 2'd0) begin
				store0_q <= rx_byte;
			end else if (cnt_q == 2'd1) begin
				store1_q <= rx_byte;
			end else if (!in_sync) begin
				store0_q <= store1_q;
				store1_q <= rx_byte;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("byte count out of range");

	a_push_full_sync: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid |-> (full_pkt && in_sync && rx_ready))
		else $error("packet pushed without a synced header");

	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full_pkt && in_sync) |=> (cnt_q == 2'd0 && btn_q == $past(btn_now)))
		else $error("accepted packet did not clear count or update buttons");

endmodule

FILE: hdl/mpd_queue.sv
// two-entry queue of decoded packets between front and back ends
// uses mpd_pkg
module mpd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  mpd_pkg::mpd_rec_t  wr_rec,
	input  logic               wr_valid,
	output logic               wr_ready,
	output mpd_pkg::mpd_rec_t  rd_rec,
	output logic               rd_valid,
	input  logic               rd_pop
);
	import mpd_pkg::*;

	mpd_rec_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_pop && rd_valid;
	assign rd_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pop |-> rd_valid)
		else $error("pop from empty queue");

endmodule

FILE: hdl/mpd_back.sv
// event emitter: turns queued packets into motion and button events
// uses mpd_pkg; drives the output register of mouse_packet_decoder
module mpd_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mpd_pkg::mpd_rec_t                rd_rec,
	input  logic                             rd_valid,
	output logic                             rd_pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output mpd_pkg::mpd_kind_t               out_kind,
	output logic [mpd_pkg::VALUE_W-1:0]      out_value,
	output logic                             out_last
);
	import mpd_pkg::*;

	mpd_rec_t            cur_q;
	logic [NUM_EV-1:0]   pend_q;
	logic                out_valid_q;
	mpd_kind_t           out_kind_q;
	logic [VALUE_W-1:0]  out_value_q;
	logic                out_last_q;

	logic [EV_IDX_W-1:0] sel_idx;
	logic [NUM_EV-1:0]   pend_next;
	logic                emit;
	logic                last_ev;
	logic [1:0]          btn_idx;
	mpd_kind_t           ev_kind;
	logic [VALUE_W-1:0]  ev_value;

	always_comb begin
		sel_idx = '0;
		for (int i = NUM_EV - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel_idx = EV_IDX_W'(i);
			end
		end
		pend_next = pend_q;
		pend_next[sel_idx] = 1'b0;
		last_ev = (pend_next == '0);
		emit = (pend_q != '0) && (!out_valid_q || out_ready);
		rd_pop = rd_valid && ((pend_q == '0) || (emit && last_ev));

		btn_idx = 2'(sel_idx - EV_BTN0);
		if (sel_idx == EV_X) begin
			ev_kind = KIND_X_MOTION;
			ev_value = cur_q.dx;
		end else if (sel_idx == EV_Y) begin
			ev_kind = KIND_Y_MOTION;
			ev_value = cur_q.dy;
		end else begin
			ev_kind = cur_q.btn_now[btn_idx] ? KIND_BTN_DOWN : KIND_BTN_UP;
			ev_value = VALUE_W'(btn_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_pop) begin
				pend_q <= rd_rec.ev_mask;
			end else if (emit) begin
				pend_q <= pend_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pop) begin
			cur_q <= rd_rec;
		end
		if (emit) begin
			out_kind_q <= ev_kind;
			out_value_q <= ev_value;
			out_last_q <= last_ev;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind = out_kind_q;
	assign out_value = out_value_q;
	assign out_last = out_last_q;

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (out_valid_q && out_last_q == $past(last_ev)))
		else $error("last flag does not match remaining events");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pop |-> ((pend_q == '0) || (emit && last_ev)))
		else $error("new packet loaded over pending events");

	a_no_empty_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pop |=> (pend_q != '0))
		else $error("queued packet carried no events");

endmodule

FILE: hdl/mouse_packet_decoder.sv
// top level of the mouse packet decoder
// instantiates mpd_front, mpd_queue and mpd_back; uses mpd_pkg
//
// Takes mouse bytes one per transaction and gathers them into three-byte packets; a packet
// whose header lacks bit 3 slides the window by one byte and yields nothing. A good packet
// yields an X event, a negated Y event (each only if nonzero) and press/release events for
// changed buttons, in that order, with tlast on the last one. The front end takes one byte
// per cycle while the two-entry packet queue has room; the back end sends one event per
// cycle while the sink is ready, from a registered output, and the input stalls only when
// two packets are still waiting in the queue.
module mouse_packet_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // event_kind[1:0], event_value[11:2], zero[15:12]
	output logic        m_axis_tlast
);
	import mpd_pkg::*;

	mpd_rec_t           wr_rec;
	logic               wr_valid;
	logic               wr_ready;
	mpd_rec_t           rd_rec;
	logic               rd_valid;
	logic               rd_pop;
	mpd_kind_t          out_kind;
	logic [VALUE_W-1:0] out_value;

	mpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (s_axis_tdata),
		.rx_valid  (s_axis_tvalid),
		.rx_ready  (s_axis_tready),
		.rec       (wr_rec),
		.rec_valid (wr_valid),
		.rec_ready (wr_ready)
	);

	mpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_rec   (wr_rec),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.rd_rec   (rd_rec),
		.rd_valid (rd_valid),
		.rd_pop   (rd_pop)
	);

	mpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_rec    (rd_rec),
		.rd_valid  (rd_valid),
		.rd_pop    (rd_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (out_kind),
		.out_value (out_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(OUT_DATA_W - VALUE_W - 2)'(0), out_value, out_kind};

endmodule

FILE: dv/mpd_tb_pkg.sv
// scoreboard for the mouse packet decoder testbench: predicts the events of each
// accepted byte and checks every output transaction against the oldest one; uses mpd_pkg
package mpd_tb_pkg;

	import mpd_pkg::*;

	typedef struct packed {
		mpd_kind_t          kind;
		logic [VALUE_W-1:0] value;
		logic               last;
	} mouse_event_t;

	class mouse_event_checker;
		logic [BYTE_W-1:0]  held_bytes [2];
		int unsigned        held;
		logic [NUM_BTN-1:0] buttons;
		mouse_event_t       pending_events [$];
		int unsigned        errors;
		int unsigned        bytes_in;
		int unsigned        events_out;
		int unsigned        packets;
		int unsigned        resyncs;

		function new();
			held = 0;
			buttons = '0;
			held_bytes[0] = '0;
			held_bytes[1] = '0;
			errors = 0;
			bytes_in = 0;
			events_out = 0;
			packets = 0;
			resyncs = 0;
		endfunction

		task report(string msg);
			$display("ERROR: %s", msg);
			errors++;
		endtask

		function void take_byte(logic [BYTE_W-1:0] rx);
			logic [BYTE_W-1:0]  hdr;
			logic [VALUE_W-1:0] dx;
			logic [VALUE_W-1:0] dy;
			mouse_event_t       found [$];
			mouse_event_t       ev;
			bytes_in++;
			if (held < 2) begin
				held_bytes[held] = rx;
				held++;
				return;
			end
			hdr = held_bytes[0];
			// header without its sync bit: slide the window by one byte
			if (!hdr[HDR_SYNC_BIT]) begin
				held_bytes[0] = held_bytes[1];
				held_bytes[1] = rx;
				resyncs++;
				return;
			end
			dx = {{2{hdr[HDR_XSIGN_BIT]}}, held_bytes[1]};
			dy = {{2{hdr[HDR_YSIGN_BIT]}}, rx};
			dy = -dy;
			if (dx != '0)
				found.push_back('{KIND_X_MOTION, dx, 1'b0});
			if (dy != '0)
				found.push_back('{KIND_Y_MOTION, dy, 1'b0});
			for (int i = 0; i < NUM_BTN; i++) begin
				if (hdr[i] && !buttons[i])
					found.push_back('{KIND_BTN_DOWN, VALUE_W'(i), 1'b0});
				else if (!hdr[i] && buttons[i])
					found.push_back('{KIND_BTN_UP, VALUE_W'(i), 1'b0});
			end
			if (found.size() > 0) begin
				ev = found[found.size()-1];
				ev.last = 1'b1;
				found[found.size()-1] = ev;
			end
			foreach (found[i])
				pending_events.push_back(found[i]);
			buttons = hdr[NUM_BTN-1:0];
			held = 0;
			packets++;
		endfunction

		task check_event(logic [OUT_DATA_W-1:0] data, logic last);
			mouse_event_t       want;
			mpd_kind_t          kind;
			logic [VALUE_W-1:0] value;
			kind = mpd_kind_t'(data[1:0]);
			value = data[VALUE_W+1:2];
			events_out++;
			if (pending_events.size() == 0) begin
				report($sformatf("unexpected event %s value %0d", kind.name(), $signed(value)));
				return;
			end
			want = pending_events.pop_front();
			if (kind !== want.kind)
				report($sformatf("event %0d kind %s, expected %s", events_out, kind.name(),
					want.kind.name()));
			if (value !== want.value)
				report($sformatf("event %0d value %0d, expected %0d", events_out,
					$signed(value), $signed(want.value)));
			if (last !== want.last)
				report($sformatf("event %0d tlast %b, expected %b", events_out, last,
					want.last));
			if (data[OUT_DATA_W-1:VALUE_W+2] !== '0)
				report($sformatf("event %0d padding bits %h", events_out,
					data[OUT_DATA_W-1:VALUE_W+2]));
		endtask

		task finish_check();
			if (pending_events.size() != 0)
				report($sformatf("%0d expected events never arrived", pending_events.size()));
		endtask
	endclass

endpackage

FILE: dv/tb_mouse_packet_decoder.sv
// top of the mouse packet decoder testbench: clock, reset, byte driver and event sink
// with random idling; depends on mpd_pkg, mpd_tb_pkg and the mouse_packet_decoder rtl
module tb_mouse_packet_decoder;

	timeunit 1ns;
	timeprecision 1ps;

	import mpd_pkg::*;
	import mpd_tb_pkg::*;

	localparam int unsigned RANDOM_BYTES = 108;
	localparam int unsigned CALM_TAIL = 30;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 16;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	mouse_event_checker events_chk = new();
	bit                 idle_on = 1'b1;
	int unsigned        cycles = 0;
	int unsigned        stall_left = 0;
	int unsigned        sent = 0;

	mouse_packet_decoder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// event sink with random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && arst_n && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// transaction monitor and run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				events_chk.take_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				events_chk.check_event(m_axis_tdata, m_axis_tlast);
		end
	end

	task automatic send_byte(logic [BYTE_W-1:0] rx);
		int unsigned gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rx;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_packet(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] x,
			logic [BYTE_W-1:0] y);
		send_byte(hdr);
		send_byte(x);
		send_byte(y);
	endtask

	task automatic send_unsynced();
		logic [BYTE_W-1:0] rx;
		rx = BYTE_W'($urandom);
		rx[HDR_SYNC_BIT] = 1'b0;
		send_byte(rx);
	endtask

	initial begin
		logic [BYTE_W-1:0]  hdr;
		logic [BYTE_W-1:0]  x;
		logic [BYTE_W-1:0]  y;
		logic [NUM_BTN-1:0] btn;
		int unsigned        pick;
		int unsigned        stop_at;
		btn = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero motion and no button change
		send_packet(8'h08, 8'h00, 8'h00);
		// largest positive deltas, every button pressed
		send_packet(8'h0F, 8'hFF, 8'hFF);
		// most negative deltas, every button released
		send_packet(8'h38, 8'h00, 8'h00);
		send_packet(8'h1A, 8'h01, 8'h80);
		// two headers without sync bit before a good packet
		send_byte(8'h00);
		send_byte(8'h07);
		send_packet(8'h28, 8'h05, 8'hFF);
		// overflow bits set
		send_packet(8'hC9, 8'h7F, 8'h01);
		send_packet(8'h29, 8'h00, 8'h00);

		stop_at = sent + RANDOM_BYTES;
		while (sent < stop_at) begin
			if (sent + CALM_TAIL >= stop_at)
				idle_on <= 1'b0;
			else
				idle_on <= ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_unsynced();
			end else if (pick == 1) begin
				// junk, then two unsynced bytes to realign the window
				repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
				send_unsynced();
				send_unsynced();
			end else begin
				hdr = BYTE_W'($urandom);
				hdr[HDR_SYNC_BIT] = 1'b1;
				if ($urandom_range(0, 2) == 0)
					hdr[NUM_BTN-1:0] = btn;
				btn = hdr[NUM_BTN-1:0];
				x = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom);
				y = ($urandom_range(0, 3) == 0) ? '0 : BYTE_W'($urandom);
				send_packet(hdr, x, y);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (events_chk.pending_events.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		events_chk.finish_check();

		$display("run sent %0d bytes: %0d packets decoded, %0d header resyncs",
			events_chk.bytes_in, events_chk.packets, events_chk.resyncs);
		$display("%0d events checked, %0d mismatches", events_chk.events_out,
			events_chk.errors);
		if (events_chk.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
